// ===== src/bba_pkg.sv =====
package bba_pkg;

  localparam int MAX_BLOCKS_DEF    = 65536;
  localparam int MAP_WORD_BITS_DEF = 64;
  localparam int TOTAL_RESET       = 65536;

  // request codes
  localparam logic [2:0] REQ_FORMAT  = 3'd0;
  localparam logic [2:0] REQ_ALLOC   = 3'd1;
  localparam logic [2:0] REQ_RELEASE = 3'd2;
  localparam logic [2:0] REQ_READ    = 3'd3;
  localparam logic [2:0] REQ_WRITE   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] block_index;
    logic        bit_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_index;
    logic        bit_read;
    logic [16:0] free_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DONE
  } state_t;

endpackage

// ===== src/bitmap_block_allocator.sv =====
// First-fit block allocator over a used/free bitmap (1 used, 0 free) held in a
// single-port-write, registered-read RAM of ceil(MAX_BLOCKS/MAP_WORD_BITS) words, plus
// a free-block counter. Requests: format, allocate (lowest free block below the
// limit), release, read bit and write bit; each request transaction yields one
// response transaction. The limit is min(total_blocks, MAX_BLOCKS); writing
// total_blocks touches neither the map nor the counter and takes effect on the
// next format and range checks. Rejected or unknown requests go straight from
// acceptance to the hand-off state; release, read bit and write bit pass
// through one map word read and then an evaluate step that modifies the word
// and writes it back where the request changes it; allocate repeats the read
// and evaluate steps for each map word scanned, up to ceil(limit/MAP_WORD_BITS)
// words; format runs the clearing pass, which writes one map word per cycle,
// before the hand-off. The hand-off waits while the previous response is still
// held. After reset the same clearing pass runs over every map word with
// req_ready low; cfg writes are taken throughout. The response sits in an
// output register, so the next request can be accepted while it waits.
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS    = bba_pkg::MAX_BLOCKS_DEF,
  parameter int MAP_WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [16:0]   cfg_wdata,
  input  logic          req_valid,
  output logic          req_ready,
  input  bba_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bba_pkg::rsp_t rsp
);

  localparam int W     = MAP_WORD_BITS;
  localparam int LOGW  = $clog2(W);
  localparam int DEPTH = (MAX_BLOCKS + W - 1) / W;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FREE_RESET = (bba_pkg::TOTAL_RESET < MAX_BLOCKS) ?
                              bba_pkg::TOTAL_RESET : MAX_BLOCKS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // lowest set bit, binary search over halves (LOGW steps)
  function automatic logic [LOGW-1:0] lowest_set(input logic [W-1:0] v);
    logic [W-1:0]    t;
    logic [LOGW-1:0] p;
    t = v;
    p = '0;
    for (int s = LOGW - 1; s >= 0; s--) begin
      if ((t & ({W{1'b1}} >> (W - (1 << s)))) == '0) begin
        p[s] = 1'b1;
        t = t >> (1 << s);
      end
    end
    return p;
  endfunction

  // map RAM
  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata;
  logic         we;
  logic [W-1:0] wd;

  // registers
  bba_pkg::state_t state, state_next;
  bba_pkg::req_t   op, op_next;
  logic [AW-1:0]   addr, addr_next;
  logic [AW-1:0]   last_word, last_word_next;
  logic [W-1:0]    last_mask, last_mask_next;
  logic            fmt_pending, fmt_pending_next;
  logic [1:0]      res_status, res_status_next;
  logic [15:0]     res_index, res_index_next;
  logic            res_bit, res_bit_next;
  logic [16:0]     free_blocks, free_blocks_next;
  logic [16:0]     total_blocks;
  bba_pkg::rsp_t   rsp_next;
  logic            rsp_valid_next;

  // scan / modify datapath
  logic [16:0]        lim;
  logic [16:0]        lim_m1;
  logic               idx_out;
  logic [W-1:0]       cand;
  logic               found;
  logic [LOGW-1:0]    found_pos;
  logic [AW+LOGW-1:0] found_full;
  logic [LOGW-1:0]    bitpos;
  logic [W-1:0]       bit_oh;
  logic [W-1:0]       found_oh;

  assign lim     = (32'(total_blocks) < 32'(MAX_BLOCKS)) ? total_blocks : 17'(MAX_BLOCKS);
  assign lim_m1  = lim - 17'd1;
  assign idx_out = {1'b0, req.block_index} >= lim;

  // only bits below the limit are candidates in the last word
  assign cand       = ~rdata & ((addr == last_word) ? last_mask : {W{1'b1}});
  assign found      = |cand;
  assign found_pos  = lowest_set(cand);
  assign found_full = {addr, found_pos};
  assign found_oh   = W'(1) << found_pos;
  assign bitpos     = op.block_index[LOGW-1:0];
  assign bit_oh     = W'(1) << bitpos;

  assign req_ready = (state == bba_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wd;
    end
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bba_pkg::S_CLEAR;
      addr         <= '0;
      fmt_pending  <= 1'b0;
      free_blocks  <= 17'(FREE_RESET);
      total_blocks <= 17'(bba_pkg::TOTAL_RESET);
      rsp_valid    <= 1'b0;
    end else begin
      state       <= state_next;
      addr        <= addr_next;
      fmt_pending <= fmt_pending_next;
      free_blocks <= free_blocks_next;
      rsp_valid   <= rsp_valid_next;
      if (cfg_we) begin
        total_blocks <= cfg_wdata;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    op         <= op_next;
    last_word  <= last_word_next;
    last_mask  <= last_mask_next;
    res_status <= res_status_next;
    res_index  <= res_index_next;
    res_bit    <= res_bit_next;
    rsp        <= rsp_next;
  end

  always_comb begin
    state_next       = state;
    op_next          = op;
    addr_next        = addr;
    last_word_next   = last_word;
    last_mask_next   = last_mask;
    fmt_pending_next = fmt_pending;
    res_status_next  = res_status;
    res_index_next   = res_index;
    res_bit_next     = res_bit;
    free_blocks_next = free_blocks;
    rsp_next         = rsp;
    rsp_valid_next   = rsp_valid && !rsp_ready;
    we               = 1'b0;
    wd               = '0;

    case (state)
      // one map word zeroed per cycle, after reset or on format
      bba_pkg::S_CLEAR: begin
        we = 1'b1;
        wd = '0;
        if (addr == LAST_ADDR) begin
          addr_next = '0;
          if (fmt_pending) begin
            fmt_pending_next = 1'b0;
            free_blocks_next = lim;
            state_next       = bba_pkg::S_DONE;
          end else begin
            state_next = bba_pkg::S_IDLE;
          end
        end else begin
          addr_next = addr + AW'(1);
        end
      end

      bba_pkg::S_IDLE: begin
        if (req_valid) begin
          op_next         = req;
          res_status_next = bba_pkg::ST_OK;
          res_index_next  = req.block_index;
          res_bit_next    = 1'b0;
          last_word_next  = AW'(lim_m1 >> LOGW);
          last_mask_next  = {W{1'b1}} >> (LOGW'(W - 1) - lim_m1[LOGW-1:0]);
          addr_next       = AW'(req.block_index >> LOGW);
          state_next      = bba_pkg::S_READ;
          case (req.req_type)
            bba_pkg::REQ_FORMAT: begin
              res_index_next   = '0;
              addr_next        = '0;
              fmt_pending_next = 1'b1;
              state_next       = bba_pkg::S_CLEAR;
            end
            bba_pkg::REQ_ALLOC: begin
              res_index_next = '0;
              addr_next      = '0;
              // empty counter or zero limit: nothing to scan
              if (free_blocks == '0 || lim == '0) begin
                res_status_next = bba_pkg::ST_NO_FREE;
                state_next      = bba_pkg::S_DONE;
              end
            end
            bba_pkg::REQ_RELEASE, bba_pkg::REQ_READ, bba_pkg::REQ_WRITE: begin
              if (idx_out) begin
                res_status_next = bba_pkg::ST_RANGE;
                state_next      = bba_pkg::S_DONE;
              end
            end
            default: begin
              // unknown code: echo index, no state change
              state_next = bba_pkg::S_DONE;
            end
          endcase
        end
      end

      // RAM read of map word at addr is in flight
      bba_pkg::S_READ: begin
        state_next = bba_pkg::S_EVAL;
      end

      bba_pkg::S_EVAL: begin
        state_next = bba_pkg::S_DONE;
        case (op.req_type)
          bba_pkg::REQ_ALLOC: begin
            if (found) begin
              we               = 1'b1;
              wd               = rdata | found_oh;
              res_index_next   = 16'(found_full);
              free_blocks_next = free_blocks - 17'd1;
            end else if (addr == last_word) begin
              res_status_next = bba_pkg::ST_NO_FREE;
            end else begin
              addr_next  = addr + AW'(1);
              state_next = bba_pkg::S_READ;
            end
          end
          bba_pkg::REQ_RELEASE: begin
            we = 1'b1;
            wd = rdata & ~bit_oh;
            if (free_blocks < lim) begin
              free_blocks_next = free_blocks + 17'd1;
            end
          end
          bba_pkg::REQ_READ: begin
            res_bit_next = rdata[bitpos];
          end
          bba_pkg::REQ_WRITE: begin
            we = 1'b1;
            wd = op.bit_value ? (rdata | bit_oh) : (rdata & ~bit_oh);
          end
          default: begin
          end
        endcase
      end

      // hand result to the output register once it is free
      bba_pkg::S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_next.status       = res_status;
          rsp_next.result_index = res_index;
          rsp_next.bit_read     = res_bit;
          rsp_next.free_count   = free_blocks;
          rsp_valid_next        = 1'b1;
          state_next            = bba_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = bba_pkg::S_IDLE;
      end
    endcase
  end

  // a response only ever comes out of the hand-off state
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == bba_pkg::S_DONE))
    else $error("response raised outside hand-off");

  // an allocated block always lies below the limit
  a_alloc_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == bba_pkg::S_EVAL && op.req_type == bba_pkg::REQ_ALLOC && found)
      |-> (32'(found_full) < 32'(lim)))
    else $error("allocated block beyond limit");

  // a successful allocation takes exactly one block off the counter
  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    (state == bba_pkg::S_EVAL && op.req_type == bba_pkg::REQ_ALLOC && found)
      |=> (free_blocks == $past(free_blocks) - 17'd1))
    else $error("free counter not decremented on allocation");

  // no request is taken while the map is being cleared
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == bba_pkg::S_CLEAR && addr != LAST_ADDR) |=> !req_ready)
    else $error("request accepted during clearing pass");

endmodule
